// File: rtl/utcd_pkg.sv
// ----------------------------------------------------------------------------
// utcd_pkg
// Shared constants, types and helpers of the Unix time to civil date unit.
// ----------------------------------------------------------------------------
package utcd_pkg;

	localparam int SECS_W     = 32;
	localparam int TZ_W       = 5;
	localparam int YEAR_W     = 12;
	localparam int MONTH_W    = 4;
	localparam int DAY_W      = 5;
	localparam int HOUR_W     = 5;
	localparam int MINUTE_W   = 6;
	localparam int SECOND_W   = 6;

	localparam int STAGES     = 8;

	localparam int SecsPerHour    = 3600;
	localparam int SecsPerDay     = 86400;
	localparam int EpochShift     = 719468;
	localparam int DaysPerEra     = 146097;
	localparam int PlausibleYear  = 2020;

	// reciprocals: floor(n / d) == (n * M) >> S over the stated input range
	localparam int RecipDay675    = 101806633;  // n < 2**26, shift 36
	localparam int RecipHour225   = 9321;       // n < 2**13, shift 21
	localparam int RecipMin15     = 1093;       // n < 2**10, shift 14
	localparam int Recip1460      = 367720;     // n < 2**18, shift 29
	localparam int Recip365       = 367720;     // n < 2**18, shift 27
	localparam int Recip153       = 3427;       // n < 2**11, shift 19

	typedef struct packed {
		logic [STAGES-1:0] en;
		logic [STAGES-1:0] vld;
	} utcd_pipe_t;

	// first day of the shifted month (March based) within the year
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/utcd_if.sv
// ----------------------------------------------------------------------------
// utcd channel interfaces
// Valid/ready channels for timestamps, civil dates and the offset register.
// ----------------------------------------------------------------------------
interface utcd_in_if import utcd_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [SECS_W-1:0] unix_seconds;

	modport source (output valid, output unix_seconds, input ready);
	modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface utcd_out_if import utcd_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]  month;
	logic [DAY_W-1:0]    day;
	logic [HOUR_W-1:0]   hour;
	logic [MINUTE_W-1:0] minute;
	logic [SECOND_W-1:0] second;
	logic                plausible;

	modport source (output valid, output year, output month, output day, output hour,
		output minute, output second, output plausible, input ready);
	modport sink   (input valid, input year, input month, input day, input hour,
		input minute, input second, input plausible, output ready);
endinterface

interface utcd_cfg_if import utcd_pkg::*; ;
	logic            valid;
	logic            ready;
	logic [TZ_W-1:0] tz_hours;

	modport source (output valid, output tz_hours, input ready);
	modport sink   (input valid, input tz_hours, output ready);
endinterface

// File: rtl/utcd_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// utcd_pipe_ctrl
// Per-stage valid bits and load enables; a stage loads when it is empty or
// its successor loads, so bubbles close up under backpressure.
// ----------------------------------------------------------------------------
module utcd_pipe_ctrl import utcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	output utcd_pipe_t pipe
);

	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] en;

	always_comb begin
		en[STAGES-1] = !vld_q[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign pipe.en  = en;
	assign pipe.vld = vld_q;

endmodule

// File: rtl/unix_time_to_civil_date_unit.sv
// ----------------------------------------------------------------------------
// unix_time_to_civil_date_unit
// Converts a 32-bit Unix seconds count, shifted by a whole-hour zone offset,
// into civil year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
// Eight register stages, one timestamp accepted per cycle when the output is
// not stalled. Every division is a constant reciprocal multiply; the longest
// stage is one 26x27 multiply. The last stage register drives the outputs
// through combinational month, day and year logic; backpressure stalls only
// occupied stages, so empty stages keep taking input. The offset register
// takes a write every cycle and must only change while no transfer is in flight.
// ----------------------------------------------------------------------------
module unix_time_to_civil_date_unit import utcd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	utcd_in_if.sink    in_ch,
	utcd_out_if.source out_ch,
	utcd_cfg_if.sink   cfg
);

	utcd_pipe_t pipe;

	utcd_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.pipe      (pipe)
	);

	assign in_ch.ready = pipe.en[0];
	assign cfg.ready   = 1'b1;

	logic signed [TZ_W-1:0] tz_hours_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_hours_q <= '0;
		end else if (cfg.valid) begin
			tz_hours_q <= $signed(cfg.tz_hours);
		end
	end

	// stage 0: biased sum, one day added so it stays positive
	logic signed [16:0] tz_off;
	logic signed [33:0] sum0;
	assign tz_off = 17'(tz_hours_q * 17'sd3600);
	assign sum0   = $signed({2'b00, in_ch.unix_seconds}) + 34'(tz_off)
		+ 34'(SecsPerDay);

	logic [32:0] u_s1;
	always_ff @(posedge clk) begin
		if (pipe.en[0]) u_s1 <= sum0[32:0];
	end

	// stage 1: days + 1 = (u >> 7) / 675
	logic [52:0] dprod;
	assign dprod = u_s1[32:7] * 27'(RecipDay675);

	logic [15:0] dayp1_s2;
	logic [9:0]  q0lo_s2;
	logic [6:0]  low7_s2;
	always_ff @(posedge clk) begin
		if (pipe.en[1]) begin
			dayp1_s2 <= dprod[51:36];
			q0lo_s2  <= u_s1[16:7];
			low7_s2  <= u_s1[6:0];
		end
	end

	// stage 2: seconds of day, era and day of era
	logic [25:0] qm;
	logic [9:0]  r675;
	logic [19:0] z;
	logic        era5;
	logic [17:0] doe;
	assign qm   = 26'(dayp1_s2) * 26'd675;
	assign r675 = q0lo_s2 - qm[9:0];
	assign z    = 20'(dayp1_s2) + 20'(EpochShift - 1);
	assign era5 = z >= 20'(5 * DaysPerEra);
	assign doe  = 18'(z - (era5 ? 20'(5 * DaysPerEra) : 20'(4 * DaysPerEra)));

	logic [16:0] rem_s3;
	logic [17:0] doe_s3;
	logic        era5_s3;
	always_ff @(posedge clk) begin
		if (pipe.en[2]) begin
			rem_s3  <= {r675, low7_s2};
			doe_s3  <= doe;
			era5_s3 <= era5;
		end
	end

	// stage 3: hour, doe / 1460 and the century terms
	logic [26:0] hprod;
	logic [36:0] p1460;
	logic [2:0]  c36524;
	assign hprod  = rem_s3[16:4] * 14'(RecipHour225);
	assign p1460  = doe_s3 * 19'(Recip1460);
	assign c36524 = 3'(doe_s3 >= 18'd36524) + 3'(doe_s3 >= 18'd73048)
		+ 3'(doe_s3 >= 18'd109572) + 3'(doe_s3 >= 18'd146096);

	logic [16:0] rem_s4;
	logic [17:0] doe_s4;
	logic        era5_s4;
	logic [4:0]  hh_s4;
	logic [6:0]  d1460_s4;
	logic [2:0]  c36524_s4;
	logic        c146096_s4;
	always_ff @(posedge clk) begin
		if (pipe.en[3]) begin
			rem_s4     <= rem_s3;
			doe_s4     <= doe_s3;
			era5_s4    <= era5_s3;
			hh_s4      <= hprod[25:21];
			d1460_s4   <= p1460[35:29];
			c36524_s4  <= c36524;
			c146096_s4 <= doe_s3 == 18'(DaysPerEra - 1);
		end
	end

	// stage 4: seconds of hour and year-of-era numerator
	logic [16:0] hsec;
	logic [17:0] ynum;
	assign hsec = 17'(hh_s4) * 17'(SecsPerHour);
	assign ynum = doe_s4 - 18'(d1460_s4) + 18'(c36524_s4) - 18'(c146096_s4);

	logic [11:0] rest_s5;
	logic [17:0] ynum_s5;
	logic [17:0] doe_s5;
	logic        era5_s5;
	logic [4:0]  hh_s5;
	always_ff @(posedge clk) begin
		if (pipe.en[4]) begin
			rest_s5 <= 12'(rem_s4 - hsec);
			ynum_s5 <= ynum;
			doe_s5  <= doe_s4;
			era5_s5 <= era5_s4;
			hh_s5   <= hh_s4;
		end
	end

	// stage 5: year of era and minute
	logic [36:0] yprod;
	logic [20:0] mprod;
	assign yprod = ynum_s5 * 19'(Recip365);
	assign mprod = rest_s5[11:2] * 11'(RecipMin15);

	logic [8:0]  yoe_s6;
	logic [5:0]  mm_s6;
	logic [11:0] rest_s6;
	logic [17:0] doe_s6;
	logic        era5_s6;
	logic [4:0]  hh_s6;
	always_ff @(posedge clk) begin
		if (pipe.en[5]) begin
			yoe_s6  <= yprod[35:27];
			mm_s6   <= mprod[19:14];
			rest_s6 <= rest_s5;
			doe_s6  <= doe_s5;
			era5_s6 <= era5_s5;
			hh_s6   <= hh_s5;
		end
	end

	// stage 6: day of year, second, base year
	logic [17:0] ydays;
	logic [1:0]  c100;
	logic [11:0] msec;
	assign c100  = 2'(yoe_s6 >= 9'd100) + 2'(yoe_s6 >= 9'd200) + 2'(yoe_s6 >= 9'd300);
	assign ydays = 18'(yoe_s6) * 18'd365 + 18'(yoe_s6[8:2]) - 18'(c100);
	assign msec  = 12'(mm_s6) * 12'd60;

	logic [8:0]        doy_s7;
	logic [YEAR_W-1:0] y_s7;
	logic [4:0]        hh_s7;
	logic [5:0]        mm_s7;
	logic [5:0]        ss_s7;
	always_ff @(posedge clk) begin
		if (pipe.en[6]) begin
			doy_s7 <= 9'(doe_s6 - ydays);
			y_s7   <= (era5_s6 ? 12'd2000 : 12'd1600) + 12'(yoe_s6);
			hh_s7  <= hh_s6;
			mm_s7  <= mm_s6;
			ss_s7  <= 6'(rest_s6 - msec);
		end
	end

	// stage 7: shifted month
	logic [10:0] mnum;
	logic [22:0] mpprod;
	logic [3:0]  mp;
	assign mnum   = 11'(doy_s7) * 11'd5 + 11'd2;
	assign mpprod = mnum * 12'(Recip153);
	assign mp     = mpprod[22:19];

	logic [3:0]        mp_s8;
	logic [8:0]        doy_s8;
	logic [YEAR_W-1:0] y_s8;
	logic [4:0]        hh_s8;
	logic [5:0]        mm_s8;
	logic [5:0]        ss_s8;
	always_ff @(posedge clk) begin
		if (pipe.en[7]) begin
			mp_s8  <= mp;
			doy_s8 <= doy_s7;
			y_s8   <= y_s7;
			hh_s8  <= hh_s7;
			mm_s8  <= mm_s7;
			ss_s8  <= ss_s7;
		end
	end

	// output stage: civil month, day, January/February carry into year
	logic [3:0]        mo;
	logic [YEAR_W-1:0] year_out;
	assign mo       = (mp_s8 < 4'd10) ? mp_s8 + 4'd3 : mp_s8 - 4'd9;
	assign year_out = y_s8 + 12'(mo <= 4'd2);

	assign out_ch.valid     = pipe.vld[STAGES-1];
	assign out_ch.year      = year_out;
	assign out_ch.month     = mo;
	assign out_ch.day       = 5'(doy_s8 - month_start(mp_s8) + 9'd1);
	assign out_ch.hour      = hh_s8;
	assign out_ch.minute    = mm_s8;
	assign out_ch.second    = ss_s8;
	assign out_ch.plausible = year_out >= 12'(PlausibleYear);

	a_fields_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.month >= 4'd1 && out_ch.month <= 4'd12
			&& out_ch.day >= 5'd1 && out_ch.day <= 5'd31 && out_ch.hour <= 5'd23
			&& out_ch.minute <= 6'd59 && out_ch.second <= 6'd59))
		else $error("civil date field out of range");

	a_no_stall_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.ready |-> in_ch.ready)
		else $error("input blocked while output is drained");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> pipe.vld[0])
		else $error("accepted transfer not captured in first stage");

endmodule
